// ===== sv/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared codes and types for the rational fraction ALU: operation codes,
// working register indexes and the controller to datapath command/status.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int WORD_BITS_DEF = 64;

  // Operation codes carried by the command field.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Working register indexes in the datapath.
  localparam logic [2:0] RG_LN = 3'd0;
  localparam logic [2:0] RG_LD = 3'd1;
  localparam logic [2:0] RG_RN = 3'd2;
  localparam logic [2:0] RG_RD = 3'd3;
  localparam logic [2:0] RG_N  = 3'd4;
  localparam logic [2:0] RG_D  = 3'd5;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_GCD_INIT,
    DP_GCD_STEP,
    DP_GCD_FIN,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WR,
    DP_MUL_INIT,
    DP_MUL_STEP,
    DP_MUL_WR,
    DP_ADD_WR,
    DP_SUB_WR,
    DP_NEG_WR,
    DP_ZERO_RES,
    DP_DZ_RES,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] sel_a;
    logic [2:0] sel_b;
    logic [2:0] dst;
  } dp_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic ln_zero;
    logic rn_zero;
    logic gcd_eq;
    logic cnt_last;
  } dp_sts_t;

endpackage

// ===== sv/rfa_datapath.sv =====
// ----------------------------------------------------------------------------
// rfa_datapath
// Working registers, binary GCD unit, restoring divider, shift-add
// multiplier and result register of the rational fraction ALU.
// ----------------------------------------------------------------------------
module rfa_datapath #(
  parameter int W = rfa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  rfa_pkg::dp_cmd_t   cmd,
  output rfa_pkg::dp_sts_t   sts,
  input  logic signed [63:0] in_left_num,
  input  logic [62:0]        in_left_den,
  input  logic signed [63:0] in_right_num,
  input  logic [62:0]        in_right_den,
  output logic signed [63:0] out_result_num,
  output logic [62:0]        out_result_den,
  output logic               out_div_by_zero,
  output logic               out_overflow
);
  import rfa_pkg::*;

  localparam int CW = $clog2(W);
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] r0_r, r1_r, r2_r, r3_r, r4_r, r5_r;
  logic [W-1:0] ga_r, gb_r, g_r;
  logic [CW-1:0] k_r, cnt_r;
  logic [W-1:0] rem_r, quo_r, hi_r, lo_r, mb_r;
  logic sneg_r, ovf_r, dz_r;
  logic signed [63:0] num_out_r;
  logic [62:0] den_out_r;
  logic dz_out_r, ovf_out_r;

  logic [W-1:0] opa, opb, sum_add, sum_sub, nrem, mres, mlim, wr_val;
  logic [W:0] trial, tdiff, msum;
  logic dge, movf, wr_en;
  logic [63:0] den_ext;
  logic [W-1:0] ln_in, ld_in, rn_in, rd_in;

  function automatic logic [W-1:0] neg_w(input logic [W-1:0] x);
    return (~x) + W'(1);
  endfunction

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
    return x[W-1] ? neg_w(x) : x;
  endfunction

  function automatic logic [W-1:0] rd_sel(
    input logic [2:0] idx,
    input logic [W-1:0] v0, v1, v2, v3, v4, v5
  );
    logic [W-1:0] v;
    case (idx)
      RG_LN:   v = v0;
      RG_LD:   v = v1;
      RG_RN:   v = v2;
      RG_RD:   v = v3;
      RG_N:    v = v4;
      default: v = v5;
    endcase
    return v;
  endfunction

  always_comb begin
    logic [63:0] ln_ext, ld_ext, rn_ext, rd_ext;
    ln_ext = in_left_num;
    opa = rd_sel(cmd.sel_a, r0_r, r1_r, r2_r, r3_r, r4_r, r5_r);
    opb = rd_sel(cmd.sel_b, r0_r, r1_r, r2_r, r3_r, r4_r, r5_r);
    sum_add = opa + opb;
    sum_sub = opa - opb;
    // Restoring divider: one quotient bit per cycle.
    trial = {rem_r, quo_r[W-1]};
    dge   = trial >= {1'b0, g_r};
    tdiff = trial - {1'b0, g_r};
    nrem  = dge ? tdiff[W-1:0] : trial[W-1:0];
    // Shift-add multiplier: the product builds up in hi_r:lo_r.
    msum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mb_r} : '0);
    mlim = sneg_r ? HALF : HALF - W'(1);
    movf = (hi_r != '0) || (lo_r > mlim);
    mres = sneg_r ? neg_w(lo_r) : lo_r;
    wr_en  = 1'b0;
    wr_val = sum_add;
    case (cmd.op)
      DP_ADD_WR: wr_en = 1'b1;
      DP_SUB_WR: begin
        wr_en  = 1'b1;
        wr_val = sum_sub;
      end
      DP_MUL_WR: begin
        wr_en  = 1'b1;
        wr_val = mres;
      end
      DP_DIV_WR: begin
        wr_en  = 1'b1;
        wr_val = sneg_r ? neg_w(quo_r) : quo_r;
      end
      default: ;
    endcase
    den_ext = 64'(mag_w(r5_r));
    ld_ext = {1'b0, in_left_den};
    rn_ext = in_right_num;
    rd_ext = {1'b0, in_right_den};
    sts.a_zero   = (opa == '0);
    sts.b_zero   = (opb == '0);
    sts.ln_zero  = (r0_r == '0);
    sts.rn_zero  = (r2_r == '0);
    sts.gcd_eq   = (ga_r == gb_r);
    sts.cnt_last = (cnt_r == CW'(W - 1));
    ld_in = ld_ext[W-1:0];
    rd_in = rd_ext[W-1:0];
    ln_in = ln_ext[W-1:0];
    rn_in = rn_ext[W-1:0];
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        r0_r <= ln_in;
        r1_r <= ld_in;
        r2_r <= rn_in;
        r3_r <= rd_in;
        r4_r <= ld_in;
        r5_r <= rd_in;
      end
      DP_NEG_WR: begin
        if (r5_r[W-1]) begin
          r4_r <= neg_w(r4_r);
          r5_r <= neg_w(r5_r);
        end
      end
      DP_ZERO_RES: begin
        r4_r <= '0;
        r5_r <= W'(1);
      end
      DP_DZ_RES: begin
        r4_r <= '0;
        r5_r <= '0;
      end
      default: begin
        if (wr_en) begin
          case (cmd.dst)
            RG_LN:   r0_r <= wr_val;
            RG_LD:   r1_r <= wr_val;
            RG_RN:   r2_r <= wr_val;
            RG_RD:   r3_r <= wr_val;
            RG_N:    r4_r <= wr_val;
            default: r5_r <= wr_val;
          endcase
        end
      end
    endcase
  end

  // GCD, divider, multiplier, flags and result register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        ovf_r <= 1'b0;
        dz_r  <= 1'b0;
      end
      DP_GCD_INIT: begin
        ga_r <= mag_w(opa);
        gb_r <= mag_w(opb);
        k_r  <= '0;
      end
      DP_GCD_STEP: begin
        // Binary GCD: both operands stay nonzero, so it ends when they meet.
        if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          gb_r <= gb_r - ga_r;
        end
      end
      DP_GCD_FIN: g_r <= ga_r << k_r;
      DP_DIV_INIT: begin
        rem_r  <= '0;
        quo_r  <= mag_w(opa);
        sneg_r <= opa[W-1];
        cnt_r  <= '0;
      end
      DP_DIV_STEP: begin
        rem_r <= nrem;
        quo_r <= {quo_r[W-2:0], dge};
        cnt_r <= cnt_r + 1'b1;
      end
      DP_MUL_INIT: begin
        hi_r   <= '0;
        lo_r   <= mag_w(opa);
        mb_r   <= mag_w(opb);
        sneg_r <= opa[W-1] ^ opb[W-1];
        cnt_r  <= '0;
      end
      DP_MUL_STEP: begin
        hi_r  <= msum[W:1];
        lo_r  <= {msum[0], lo_r[W-1:1]};
        cnt_r <= cnt_r + 1'b1;
      end
      DP_MUL_WR: ovf_r <= ovf_r | movf;
      DP_ADD_WR: ovf_r <= ovf_r | ((opa[W-1] ^ sum_add[W-1]) & (opb[W-1] ^ sum_add[W-1]));
      DP_SUB_WR: ovf_r <= ovf_r | ((opa[W-1] ^ opb[W-1]) & (opa[W-1] ^ sum_sub[W-1]));
      DP_NEG_WR: begin
        // Negating the most negative word wraps to itself.
        if (r5_r[W-1]) begin
          ovf_r <= ovf_r | (r4_r == HALF) | (r5_r == HALF);
        end
      end
      DP_ZERO_RES: ovf_r <= 1'b0;
      DP_DZ_RES: begin
        ovf_r <= 1'b0;
        dz_r  <= 1'b1;
      end
      DP_OUT: begin
        num_out_r <= 64'(signed'(r4_r));
        den_out_r <= den_ext[62:0];
        dz_out_r  <= dz_r;
        ovf_out_r <= ovf_r;
      end
      default: ;
    endcase
  end

  assign out_result_num  = num_out_r;
  assign out_result_den  = den_out_r;
  assign out_div_by_zero = dz_out_r;
  assign out_overflow    = ovf_out_r;

endmodule

// ===== sv/rfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer of the rational fraction ALU: steps through a short program per
// operation and drives the datapath units one command per cycle.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  output logic             out_valid,
  input  logic             out_ready,
  output rfa_pkg::dp_cmd_t cmd,
  input  rfa_pkg::dp_sts_t sts
);
  import rfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FETCH, S_GCD, S_DIV_INIT, S_DIV, S_DIV_WR,
    S_MUL, S_MUL_WR, S_DONE
  } state_t;

  typedef enum logic [2:0] {K_CPR, K_MUL, K_ADD, K_SUB, K_NEG, K_END} kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] i;
    logic [2:0] j;
    logic [2:0] dst;
  } step_t;

  state_t state_r, state_nxt;
  logic [2:0] pc_r, pc_nxt;
  logic [1:0] op_r, op_nxt;
  logic side_r, side_nxt;
  logic out_valid_r, out_valid_nxt;
  step_t step;

  // Step program per operation; a reduction of two registers is K_CPR.
  function automatic step_t prog(input logic [1:0] c, input logic [2:0] pc);
    step_t s;
    s = '{K_END, RG_N, RG_D, RG_N};
    case (c)
      CMD_ADD, CMD_SUB: begin
        case (pc)
          3'd0: s = '{K_CPR, RG_N, RG_D, RG_N};
          3'd1: s = '{K_MUL, RG_LN, RG_D, RG_LN};
          3'd2: s = '{K_MUL, RG_RN, RG_N, RG_RN};
          3'd3: s = '{K_MUL, RG_LD, RG_D, RG_D};
          3'd4: s = '{(c == CMD_SUB) ? K_SUB : K_ADD, RG_LN, RG_RN, RG_N};
          3'd5: s = '{K_NEG, RG_N, RG_D, RG_N};
          3'd6: s = '{K_CPR, RG_N, RG_D, RG_N};
          default: ;
        endcase
      end
      CMD_MUL: begin
        case (pc)
          3'd0: s = '{K_CPR, RG_LN, RG_RD, RG_N};
          3'd1: s = '{K_CPR, RG_RN, RG_LD, RG_N};
          3'd2: s = '{K_MUL, RG_LN, RG_RN, RG_N};
          3'd3: s = '{K_MUL, RG_LD, RG_RD, RG_D};
          3'd4: s = '{K_NEG, RG_N, RG_D, RG_N};
          3'd5: s = '{K_CPR, RG_N, RG_D, RG_N};
          default: ;
        endcase
      end
      default: begin
        case (pc)
          3'd0: s = '{K_CPR, RG_LN, RG_RN, RG_N};
          3'd1: s = '{K_CPR, RG_LD, RG_RD, RG_N};
          3'd2: s = '{K_MUL, RG_LN, RG_RD, RG_N};
          3'd3: s = '{K_MUL, RG_LD, RG_RN, RG_D};
          3'd4: s = '{K_NEG, RG_N, RG_D, RG_N};
          3'd5: s = '{K_CPR, RG_N, RG_D, RG_N};
          default: ;
        endcase
      end
    endcase
    return s;
  endfunction

  always_comb begin
    step          = prog(op_r, pc_r);
    cmd           = '{DP_NOP, step.i, step.j, step.dst};
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    op_nxt        = op_r;
    side_nxt      = side_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          op_nxt    = in_command;
          pc_nxt    = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_r == CMD_MUL && (sts.ln_zero || sts.rn_zero)) begin
          cmd.op    = DP_ZERO_RES;
          state_nxt = S_DONE;
        end else if (op_r == CMD_DIV && sts.rn_zero) begin
          cmd.op    = DP_DZ_RES;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (step.kind)
          K_CPR: begin
            // A zero on either side leaves the pair as it is.
            if (sts.a_zero || sts.b_zero) begin
              pc_nxt = pc_r + 1'b1;
            end else begin
              cmd.op    = DP_GCD_INIT;
              state_nxt = S_GCD;
            end
          end
          K_MUL: begin
            cmd.op    = DP_MUL_INIT;
            state_nxt = S_MUL;
          end
          K_ADD: begin
            cmd.op = DP_ADD_WR;
            pc_nxt = pc_r + 1'b1;
          end
          K_SUB: begin
            cmd.op = DP_SUB_WR;
            pc_nxt = pc_r + 1'b1;
          end
          K_NEG: begin
            cmd.op = DP_NEG_WR;
            pc_nxt = pc_r + 1'b1;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_GCD: begin
        if (sts.gcd_eq) begin
          cmd.op    = DP_GCD_FIN;
          side_nxt  = 1'b0;
          state_nxt = S_DIV_INIT;
        end else begin
          cmd.op = DP_GCD_STEP;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = DP_DIV_INIT;
        cmd.sel_a = side_r ? step.j : step.i;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (sts.cnt_last) begin
          state_nxt = S_DIV_WR;
        end
      end
      S_DIV_WR: begin
        cmd.op  = DP_DIV_WR;
        cmd.dst = side_r ? step.j : step.i;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_DIV_INIT;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_MUL: begin
        cmd.op = DP_MUL_STEP;
        if (sts.cnt_last) begin
          state_nxt = S_MUL_WR;
        end
      end
      S_MUL_WR: begin
        cmd.op    = DP_MUL_WR;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = S_FETCH;
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      op_r        <= CMD_ADD;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      op_r        <= op_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/rational_fraction_alu_unit.sv =====
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the GCD-reduced result with division-by-zero and overflow flags.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one item: a command and two
//   fractions. The result channel (out_valid/out_ready) returns one item per
//   input item: reduced numerator, denominator magnitude and two flags.
//   One item is worked on at a time. in_ready is high only while the
//   sequencer is idle; it drops the cycle after an item is accepted.
//   Latency depends on the operands. Each multiply runs on the shift-add
//   multiplier; each reduction runs binary GCD steps until the two values
//   meet, then two passes of the restoring divider. An add or subtract runs
//   two reductions and three multiplies, a multiply or divide three
//   reductions and two multiplies. Multiplies by zero and division by zero
//   skip the program and go from the operand check straight to the result.
//   The result sits in an output register; a new item may be accepted while
//   it waits. If the receiver stalls, the next result is held back until the
//   register is free. Reset (rst_n low, synchronous) returns to idle and
//   drops out_valid.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit #(
  parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [63:0] in_left_num,
  input  logic [62:0]        in_left_den,
  input  logic signed [63:0] in_right_num,
  input  logic [62:0]        in_right_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_result_num,
  output logic [62:0]        out_result_den,
  output logic               out_div_by_zero,
  output logic               out_overflow
);
  import rfa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rfa_datapath #(.W(WORD_BITS)) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_left_num     (in_left_num),
    .in_left_den     (in_left_den),
    .in_right_num    (in_right_num),
    .in_right_den    (in_right_den),
    .out_result_num  (out_result_num),
    .out_result_den  (out_result_den),
    .out_div_by_zero (out_div_by_zero),
    .out_overflow    (out_overflow)
  );

  // An accepted item keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // Division by zero always reports 0/0 without overflow.
  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |->
      (out_result_num == 64'sd0 && out_result_den == 63'd0 && !out_overflow))
    else $error("division by zero item carries a nonzero result");

  // The result register is only loaded while the sequencer finishes an item.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_OUT) |=> out_valid)
    else $error("result loaded without out_valid");

endmodule

// ===== tb/rfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_checker
// Watches both channels of the rational fraction ALU, computes the reduced
// fraction for every accepted item and compares each result item in order.
// ----------------------------------------------------------------------------
module rfa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [63:0] in_left_num,
  input  logic [62:0]        in_left_den,
  input  logic signed [63:0] in_right_num,
  input  logic [62:0]        in_right_den,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [63:0] out_result_num,
  input  logic [62:0]        out_result_den,
  input  logic               out_div_by_zero,
  input  logic               out_overflow,
  output int                 fail_count,
  output int                 pending_count
);
  import rfa_pkg::*;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        dz;
    logic        ovf;
  } fraction_t;

  fraction_t pending_fracs[$];
  bit        ovf_flag;

  function automatic logic [63:0] magn(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] wmul(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    logic [63:0]  lo;
    logic         neg;
    p = magn(x) * magn(y);
    lo = p[63:0];
    neg = x[63] ^ y[63];
    if (p[127:64] != 0) ovf_flag = 1;
    if (lo > (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)) ovf_flag = 1;
    return neg ? 64'd0 - lo : lo;
  endfunction

  function automatic logic [63:0] wadd(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    r = x + y;
    if (((x ^ r) & (y ^ r)) >> 63) ovf_flag = 1;
    return r;
  endfunction

  function automatic logic [63:0] wsub(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    r = x - y;
    if (((x ^ y) & (x ^ r)) >> 63) ovf_flag = 1;
    return r;
  endfunction

  function automatic logic [63:0] wneg(logic [63:0] x);
    logic [63:0] r;
    r = 64'd0 - x;
    if (x != 0 && r == x) ovf_flag = 1;
    return r;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] a, b, t;
    a = magn(x);
    b = magn(y);
    if (a == 0 && b == 0) return 64'd1;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] divx(logic [63:0] x, logic [63:0] c);
    logic [63:0] m;
    m = magn(x) / c;
    return x[63] ? 64'd0 - m : m;
  endfunction

  task automatic reduce_pair(inout logic [63:0] a, inout logic [63:0] b);
    logic [63:0] c;
    if (a == 0 || b == 0) return;
    c = gcd_of(a, b);
    a = divx(a, c);
    b = divx(b, c);
  endtask

  task automatic normalize(inout logic [63:0] n, inout logic [63:0] d);
    if (d[63]) begin
      n = wneg(n);
      d = wneg(d);
    end
    reduce_pair(n, d);
  endtask

  task automatic predict_fraction(input logic [1:0] cmd, input logic [63:0] ln,
                                  input logic [62:0] ld63, input logic [63:0] rn,
                                  input logic [62:0] rd63, output fraction_t res);
    logic [63:0] ld, rd, n, d, a1, a2, b1, b2, t1, t2, dm;
    bit dz;
    ld = {1'b0, ld63};
    rd = {1'b0, rd63};
    n = 0;
    d = 1;
    dz = 0;
    ovf_flag = 0;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        b1 = ld;
        b2 = rd;
        reduce_pair(b1, b2);
        t1 = wmul(ln, b2);
        t2 = wmul(rn, b1);
        n = (cmd == CMD_ADD) ? wadd(t1, t2) : wsub(t1, t2);
        d = wmul(ld, b2);
        normalize(n, d);
      end
      CMD_MUL: begin
        if (ln != 0 && rn != 0) begin
          a1 = ln; b2 = rd; a2 = rn; b1 = ld;
          reduce_pair(a1, b2);
          reduce_pair(a2, b1);
          n = wmul(a1, a2);
          d = wmul(b1, b2);
          normalize(n, d);
        end
      end
      default: begin
        if (rn == 0) begin
          dz = 1;
          d = 0;
        end else begin
          a1 = ln; a2 = rn; b1 = ld; b2 = rd;
          reduce_pair(a1, a2);
          reduce_pair(b1, b2);
          n = wmul(a1, b2);
          d = wmul(b1, a2);
          normalize(n, d);
        end
      end
    endcase
    dm = magn(d);
    res.num = n;
    res.den = dm[62:0];
    res.dz = dz;
    res.ovf = ovf_flag;
  endtask

  always @(posedge clk) begin
    fraction_t f, e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_fraction(in_command, in_left_num, in_left_den, in_right_num,
                         in_right_den, f);
        pending_fracs.push_back(f);
      end
      if (out_valid && out_ready) begin
        if (pending_fracs.size() == 0) begin
          $display("%0t: unexpected result item num=%h den=%h", $time,
                   out_result_num, out_result_den);
          fail_count <= fail_count + 1;
        end else begin
          e = pending_fracs.pop_front();
          if (e.num !== out_result_num || e.den !== out_result_den ||
              e.dz !== out_div_by_zero || e.ovf !== out_overflow) begin
            $display("%0t: mismatch expected num=%h den=%h dz=%b ovf=%b", $time,
                     e.num, e.den, e.dz, e.ovf);
            $display("%0t:          actual num=%h den=%h dz=%b ovf=%b", $time,
                     out_result_num, out_result_den, out_div_by_zero, out_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= pending_fracs.size();
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random fraction items into the ALU with bursty input
// and a stalling receiver, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rfa_pkg::*;

  logic               clk, rst_n;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic [1:0]         in_command;
  logic signed [63:0] in_left_num, in_right_num, out_result_num;
  logic [62:0]        in_left_den, in_right_den, out_result_den;
  logic               out_div_by_zero, out_overflow;
  int                 fail_count, pending_count;

  localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

  rational_fraction_alu_unit u_dut (.*);

  rfa_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver stalls in runs whose odds change over time.
  initial begin
    int mode;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic [63:0] rand_word(int kind);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (kind)
      0: v = 64'($urandom_range(0, 40)) - 64'd20;
      1: v = $signed(v) >>> $urandom_range(0, 63);
      2: v = {$urandom_range(0, 1) ? MAXP : MINN} - $urandom_range(0, 3);
      3: v = $urandom_range(0, 1000) * (64'd1 << $urandom_range(0, 20));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [63:0] ln, logic [62:0] ld,
                           logic [63:0] rn, logic [62:0] rd);
    in_command <= cmd;
    in_left_num <= ln;
    in_left_den <= ld;
    in_right_num <= rn;
    in_right_den <= rd;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [1:0] c;
    int burst;
    int gap;
    in_valid = 0;
    in_command = CMD_ADD;
    in_left_num = 0;
    in_left_den = 1;
    in_right_num = 0;
    in_right_den = 1;
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: each operation, zero numerators, division by zero,
    // zero denominators and the extremes of every field.
    send_item(CMD_ADD, 1, 2, -1, 2);
    send_item(CMD_SUB, 3, 4, 1, 6);
    send_item(CMD_MUL, 0, 5, 7, 3);
    send_item(CMD_MUL, 6, 35, -14, 9);
    send_item(CMD_DIV, 5, 7, 0, 3);
    send_item(CMD_DIV, -4, 9, 6, 15);
    send_item(CMD_ADD, 1, 0, 1, 3);
    send_item(CMD_DIV, 0, 0, 0, 0);
    send_item(CMD_MUL, MAXP, MAXP[62:0], MAXP, 1);
    send_item(CMD_MUL, MINN, 1, MINN, 1);
    send_item(CMD_ADD, MAXP, 1, MAXP, 1);
    send_item(CMD_SUB, MINN, 1, 1, 1);
    send_item(CMD_DIV, MINN, MAXP[62:0], -1, MAXP[62:0]);
    send_item(CMD_DIV, 1, 3, MINN, 1);
    send_item(CMD_MUL, -1, MAXP[62:0], -1, 2);
    send_item(CMD_ADD, -1, 63'h4000_0000_0000_0001, 1, 63'h3FFF_FFFF_FFFF_FFFF);
    send_item(CMD_SUB, 0, 0, 0, 0);
    send_item(CMD_MUL, 0, 0, 0, 0);

    for (int i = 0; i < 2000; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      burst--;
      c = 2'($urandom_range(0, 3));
      send_item(c, rand_word($urandom_range(0, 4)), 63'(rand_word($urandom_range(0, 4))),
                ($urandom_range(0, 15) == 0) ? 64'd0 : rand_word($urandom_range(0, 4)),
                63'(rand_word($urandom_range(0, 4))));
    end
    in_valid <= 0;

    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
